// ----- src/bltd_pkg.sv -----
// ----------------------------------------------------------------------------
// bltd_pkg: shared types and constants of the byte-level token decoder
// Holds the transfer payloads, the result set passed between the decode stage
// and the output buffer, and the code point to byte mapping.
// ----------------------------------------------------------------------------
package bltd_pkg;

  // One input transfer: a byte of the token string and its end flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } in_t;

  // One output transfer: a decoded raw byte and its end flag.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // Results caused by one input byte, first result in entry 0.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num;
    logic            last;
  } res_set_t;

  // Output buffer status seen by the top level.
  typedef struct packed {
    logic can_load;
    logic busy;
  } buf_stat_t;

  // Number of bytes held in the pending buffer.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_LEAD = 2'd1;
  localparam logic [1:0] PEND_BOTH = 2'd2;

  // Lead byte patterns and payload masks.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] FOLLOW_BITS = 8'h3F;

  // Code point ranges that map straight to a byte.
  localparam logic [15:0] CP_LOW_FIRST  = 16'd33;
  localparam logic [15:0] CP_LOW_LAST   = 16'd126;
  localparam logic [15:0] CP_MID_FIRST  = 16'd161;
  localparam logic [15:0] CP_MID_LAST   = 16'd172;
  localparam logic [15:0] CP_HIGH_FIRST = 16'd174;
  localparam logic [15:0] CP_HIGH_LAST  = 16'd255;
  localparam logic [15:0] CP_SHIFTED    = 16'd256;
  localparam logic [15:0] IDX_CTRL_LAST = 16'd32;
  localparam logic [15:0] IDX_DEL_LAST  = 16'd66;
  localparam logic [7:0]  IDX_DEL_OFFS  = 8'd94;
  localparam logic [7:0]  BYTE_SOFT_HY  = 8'd173;

  // Maps a code point to a byte; bit 8 is set when the mapping applies.
  function automatic logic [8:0] map_point(input logic [15:0] cp);
    logic [15:0] idx;
    logic [8:0]  res;
    idx = cp - CP_SHIFTED;
    res = 9'd0;
    if ((cp >= CP_LOW_FIRST && cp <= CP_LOW_LAST) ||
        (cp >= CP_MID_FIRST && cp <= CP_MID_LAST) ||
        (cp >= CP_HIGH_FIRST && cp <= CP_HIGH_LAST)) begin
      res = {1'b1, cp[7:0]};
    end else if (cp >= CP_SHIFTED) begin
      if (idx <= IDX_CTRL_LAST) begin
        res = {1'b1, idx[7:0]};
      end else if (idx <= IDX_DEL_LAST) begin
        res = {1'b1, idx[7:0] + IDX_DEL_OFFS};
      end else begin
        res = {1'b1, BYTE_SOFT_HY};
      end
    end
    return res;
  endfunction

endpackage

// ----- src/bltd_decode.sv -----
// ----------------------------------------------------------------------------
// bltd_decode: sequence assembly and code point mapping
// Holds the pending lead byte and first follower, and works out the result
// set that the current byte causes. The pending state moves on advance_i.
// ----------------------------------------------------------------------------
module bltd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  bltd_pkg::in_t      item_i,
  output bltd_pkg::res_set_t res_o
);
  import bltd_pkg::*;

  logic [1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] fol_q, fol_d;

  logic [7:0]  x;
  logic        str_end;
  logic        is_lead2_x, is_lead3_x, is_lead2_p;
  logic [15:0] cp2, cp3;
  logic [8:0]  map2, map3;
  res_set_t    res;

  assign x       = item_i.data_byte;
  assign str_end = item_i.string_end;

  assign is_lead2_x = (x & LEAD2_MASK) == LEAD2_CODE;
  assign is_lead3_x = (x & LEAD3_MASK) == LEAD3_CODE;
  assign is_lead2_p = (lead_q & LEAD2_MASK) == LEAD2_CODE;

  // Code points of a completed two or three byte sequence.
  assign cp2 = {5'd0, lead_q[4:0] & LEAD2_BITS[4:0], x[5:0] & FOLLOW_BITS[5:0]};
  assign cp3 = {lead_q[3:0] & LEAD3_BITS[3:0], fol_q[5:0] & FOLLOW_BITS[5:0],
                x[5:0] & FOLLOW_BITS[5:0]};
  assign map2 = map_point(cp2);
  assign map3 = map_point(cp3);

  // Result set and next pending state.
  always_comb begin
    res        = '0;
    pend_cnt_d = PEND_NONE;
    lead_d     = lead_q;
    fol_d      = fol_q;
    unique case (pend_cnt_q)
      PEND_NONE: begin
        if ((is_lead2_x || is_lead3_x) && !str_end) begin
          lead_d     = x;
          pend_cnt_d = PEND_LEAD;
        end else begin
          res.bytes[0] = x;
          res.num      = 2'd1;
        end
      end
      PEND_LEAD: begin
        if (is_lead2_p) begin
          if (map2[8]) begin
            res.bytes[0] = map2[7:0];
            res.num      = 2'd1;
          end else begin
            res.bytes[0] = lead_q;
            res.bytes[1] = x;
            res.num      = 2'd2;
          end
        end else if (str_end) begin
          res.bytes[0] = lead_q;
          res.bytes[1] = x;
          res.num      = 2'd2;
        end else begin
          fol_d      = x;
          pend_cnt_d = PEND_BOTH;
        end
      end
      default: begin
        if (map3[8]) begin
          res.bytes[0] = map3[7:0];
          res.num      = 2'd1;
        end else begin
          res.bytes[0] = lead_q;
          res.bytes[1] = fol_q;
          res.bytes[2] = x;
          res.num      = 2'd3;
        end
      end
    endcase
    if (str_end) begin
      pend_cnt_d = PEND_NONE;
    end
    res.last = str_end;
  end

  assign res_o = res;

  // Pending count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= PEND_NONE;
    end else if (advance_i) begin
      pend_cnt_q <= pend_cnt_d;
    end
  end

  // Pending bytes; only read while the count says they are held.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      lead_q <= lead_d;
      fol_q  <= fol_d;
    end
  end

endmodule

// ----- src/bltd_outbuf.sv -----
// ----------------------------------------------------------------------------
// bltd_outbuf: result register
// Holds the up to three results of one input byte and hands them out one
// transfer per cycle while the receiver does not stall, first result first.
// ----------------------------------------------------------------------------
module bltd_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bltd_pkg::res_set_t  res_i,
  output bltd_pkg::buf_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bltd_pkg::out_t      out_data_o
);
  import bltd_pkg::*;

  logic [1:0]      num_q, num_d;
  logic [2:0][7:0] bytes_q, bytes_d;
  logic            end_q, end_d;
  logic            out_xfer, can_load, do_load;

  assign out_valid_o = num_q != 2'd0;
  assign out_xfer    = out_valid_o && !out_stall_i;
  // Free now, or the last held result leaves in this cycle.
  assign can_load    = (num_q == 2'd0) || (num_q == 2'd1 && out_xfer);
  assign do_load     = load_i && can_load;

  assign stat_o.can_load = can_load;
  assign stat_o.busy     = out_valid_o;

  assign out_data_o.out_byte = bytes_q[0];
  assign out_data_o.out_last = end_q && (num_q == 2'd1);

  // Load a new set, or shift out the result just taken.
  always_comb begin
    num_d   = num_q;
    bytes_d = bytes_q;
    end_d   = end_q;
    if (do_load) begin
      num_d   = res_i.num;
      bytes_d = res_i.bytes;
      end_d   = res_i.last;
    end else if (out_xfer) begin
      num_d      = num_q - 2'd1;
      bytes_d[0] = bytes_q[1];
      bytes_d[1] = bytes_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 2'd0;
    end else begin
      num_q <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    end_q   <= end_d;
  end

endmodule

// ----- src/byte_level_token_decoder.sv -----
// ----------------------------------------------------------------------------
// byte_level_token_decoder: byte-level BPE token string decoder
// Turns the byte-level spelling of a token string back into raw bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte of a token string per transfer, with
//   string_end set on its final byte. The output channel carries the decoded
//   raw bytes, with out_last set on the final byte decoded for a string.
//   An input byte gives no result (a buffered lead or follower byte), one, or up to three
//   (an unmapped sequence copied raw).
//   A byte passes through the input register and then the result register
//   before its first result is offered; either can hold it under a stall.
//   Throughput: one input byte per cycle while each byte gives at most one
//   result and the receiver does not stall; a byte that gives several
//   results holds the input until the single result register has drained
//   them, one transfer per unstalled cycle.
//   When the receiver stalls, the result register holds its bytes and the
//   input side stalls once both the input and the result registers are full.
//   Reset empties both registers and the pending sequence buffer.
// ----------------------------------------------------------------------------
module byte_level_token_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bltd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bltd_pkg::out_t out_data_o
);
  import bltd_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  in_t       s1_q;
  logic      in_xfer, s1_adv;
  res_set_t  res_set;
  buf_stat_t buf_stat;

  // Input register moves on when the result register can take its set.
  assign s1_adv     = s1_valid_q && buf_stat.can_load;
  assign in_stall_o = s1_valid_q && !buf_stat.can_load;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_xfer || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
  end

  bltd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .item_i    (s1_q),
    .res_o     (res_set)
  );

  bltd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv),
    .res_i       (res_set),
    .stat_o      (buf_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // The input only stalls behind a held byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // A byte that cannot move on keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("held input byte lost or changed");

  // A result register that cannot load is offering a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !buf_stat.can_load |-> (buf_stat.busy && out_valid_o))
    else $error("result register blocked while empty");

  // A stalled output transfer stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output transfer dropped or changed");
`endif

endmodule

// ----- tb/sv/tb_byte_level_token_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_level_token_decoder: self-checking bench for the token decoder
// Feeds token strings byte by byte: a short directed table first, then random
// strings built mostly from well-formed UTF-8 sequences with noise mixed in.
// Every accepted input byte is decoded by a behavioural model in the bench,
// and every output transfer is compared with the oldest expected byte.
// ----------------------------------------------------------------------------
module tb_byte_level_token_decoder;
  import bltd_pkg::*;

  localparam int RAND_ITEMS  = 250;
  localparam int QUIET_TAIL  = 40;
  localparam int HOLD_CYCLES = 48;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 2000;

  // One row of stimulus; when typed is set the expected bytes are given here.
  typedef struct packed {
    in_t             item;
    logic            typed;
    logic [1:0]      ntyp;
    logic [2:0][7:0] exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Model state of the pending sequence buffer.
  logic [7:0] pend_lead;
  logic [7:0] pend_follow;
  logic [1:0] pend_cnt;
  out_t       dec_res [3];
  int         dec_n;

  out_t decoded_q [$];
  row_t offered_q [$];
  row_t dir_tbl [$];
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic no_idle = 1'b0;

  byte_level_token_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    dec_res[dec_n] = '{out_byte: b, out_last: 1'b0};
    dec_n++;
  endfunction

  // Maps a code point to its raw byte; returns 0 when the point has no mapping.
  function automatic logic map_cp(input logic [15:0] cp, output logic [7:0] b);
    logic [15:0] idx;
    idx = cp - 16'd256;
    b = 8'd0;
    if ((cp >= 16'd33 && cp <= 16'd126) || (cp >= 16'd161 && cp <= 16'd172) ||
        (cp >= 16'd174 && cp <= 16'd255)) begin
      b = cp[7:0];
      return 1'b1;
    end
    if (cp >= 16'd256) begin
      if (idx <= 16'd32) b = idx[7:0];
      else if (idx <= 16'd66) b = idx[7:0] + 8'd94;
      else b = 8'd173;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Decodes one input byte into dec_res[0 .. dec_n-1] and updates the buffer.
  function automatic void decode_byte(input in_t it);
    logic [7:0]  x;
    logic [7:0]  b;
    logic [15:0] cp;
    logic        lead2;
    x = it.data_byte;
    dec_n = 0;
    lead2 = (pend_lead & LEAD2_MASK) == LEAD2_CODE;
    if (pend_cnt == PEND_NONE) begin
      if (x < 8'h80) begin
        add_byte(x);
      end else if ((x & LEAD2_MASK) == LEAD2_CODE || (x & LEAD3_MASK) == LEAD3_CODE) begin
        if (it.string_end) begin
          add_byte(x);
        end else begin
          pend_lead = x;
          pend_cnt = PEND_LEAD;
        end
      end else begin
        add_byte(x);
      end
    end else if (pend_cnt == PEND_LEAD && lead2) begin
      cp = {5'd0, pend_lead[4:0], x[5:0]};
      if (map_cp(cp, b)) begin
        add_byte(b);
      end else begin
        add_byte(pend_lead);
        add_byte(x);
      end
      pend_cnt = PEND_NONE;
    end else if (pend_cnt == PEND_LEAD) begin
      if (it.string_end) begin
        add_byte(pend_lead);
        add_byte(x);
        pend_cnt = PEND_NONE;
      end else begin
        pend_follow = x;
        pend_cnt = PEND_BOTH;
      end
    end else begin
      cp = {pend_lead[3:0], pend_follow[5:0], x[5:0]};
      if (map_cp(cp, b)) begin
        add_byte(b);
      end else begin
        add_byte(pend_lead);
        add_byte(pend_follow);
        add_byte(x);
      end
      pend_cnt = PEND_NONE;
    end
    if (it.string_end) begin
      pend_cnt = PEND_NONE;
      if (dec_n > 0) dec_res[dec_n-1].out_last = 1'b1;
    end
  endfunction

  // Builds a stimulus row; n below zero leaves the expectation to the model.
  function automatic row_t mk_row(input logic [7:0] b, input logic fin, input int n,
                                  input logic [7:0] e0 = 8'd0, input logic [7:0] e1 = 8'd0,
                                  input logic [7:0] e2 = 8'd0);
    row_t r;
    r.item = '{data_byte: b, string_end: fin};
    r.typed = (n >= 0);
    r.ntyp = (n >= 0) ? n[1:0] : 2'd0;
    r.exp[0] = e0;
    r.exp[1] = e1;
    r.exp[2] = e2;
    return r;
  endfunction

  // Output check and prediction, both on the rising edge.
  always @(posedge clk_i) begin : check_and_predict
    out_t got;
    out_t want;
    row_t r;
    int   k;
    if (rst_ni === 1'b1) begin
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
          if (got.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %b, expected %b on byte %02h",
                                      got.out_last, want.out_last, want.out_byte));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        r = offered_q.pop_front();
        decode_byte(r.item);
        if (r.typed) begin
          for (k = 0; k < int'(r.ntyp); k++) begin
            want = '{out_byte: r.exp[k], out_last: r.item.string_end && k == r.ntyp - 1};
            decoded_q.push_back(want);
          end
        end else begin
          for (k = 0; k < dec_n; k++) decoded_q.push_back(dec_res[k]);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin : receiver
    int   burst_left;
    logic burst_val;
    logic hold_taken;
    burst_left = 0;
    burst_val = 1'b0;
    hold_taken = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_val = ($urandom_range(0, 2) == 0);
          burst_left = $urandom_range(1, 7);
        end
        out_stall_i <= burst_val;
        burst_left--;
      end
    end
  end

  // Offers one row, after an optional idle burst, and waits for its transfer.
  task automatic send_row(input row_t r);
    int gap;
    gap = (no_idle || hold_left > 0 || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    offered_q.push_back(r);
    in_valid_i <= 1'b1;
    in_data_i <= r.item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Holds the input idle until every expected byte has come out.
  task automatic drain_wait();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0 || offered_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_follow();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(1, 255));
  endfunction

  // Main sequence.
  initial begin : stimulus
    logic [7:0] str [$];
    logic [7:0] lead;
    int         n_rand;
    int         units;
    int         kind;
    int         i;
    logic       paused;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    pend_lead = 8'd0;
    pend_follow = 8'd0;
    pend_cnt = PEND_NONE;
    n_rand = 0;
    paused = 1'b0;

    // Directed table: plain bytes, mapped ranges and their edges, raw copies,
    // cut-off sequences at the end of a string and stray lead bytes.
    dir_tbl.push_back(mk_row(8'h41, 1'b1, 1, 8'h41));
    dir_tbl.push_back(mk_row(8'h01, 1'b0, 1, 8'h01));
    dir_tbl.push_back(mk_row(8'h7F, 1'b1, 1, 8'h7F));
    dir_tbl.push_back(mk_row(8'hC4, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'h80, 1'b1, 1, 8'h00));
    dir_tbl.push_back(mk_row(8'hC4, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'hA1, 1'b0, 1, 8'h7F));
    dir_tbl.push_back(mk_row(8'hC5, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'h83, 1'b1, 1, 8'hAD));
    dir_tbl.push_back(mk_row(8'hC2, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'hAD, 1'b1, 2, 8'hC2, 8'hAD));
    dir_tbl.push_back(mk_row(8'hC3, 1'b1, 1, 8'hC3));
    dir_tbl.push_back(mk_row(8'hE0, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'h80, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'h80, 1'b1, 3, 8'hE0, 8'h80, 8'h80));
    dir_tbl.push_back(mk_row(8'hEF, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'hBF, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'hBF, 1'b1, 1, 8'hAD));
    dir_tbl.push_back(mk_row(8'hE2, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'h82, 1'b1, 2, 8'hE2, 8'h82));
    dir_tbl.push_back(mk_row(8'h80, 1'b0, 1, 8'h80));
    dir_tbl.push_back(mk_row(8'hFF, 1'b0, 1, 8'hFF));
    dir_tbl.push_back(mk_row(8'hF0, 1'b1, 1, 8'hF0));
    dir_tbl.push_back(mk_row(8'hC5, 1'b0, 0));
    dir_tbl.push_back(mk_row(8'h82, 1'b1, 1, 8'hA0));
    dir_tbl.push_back(mk_row(8'hC2, 1'b0, -1));
    dir_tbl.push_back(mk_row(8'hA1, 1'b1, -1));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[j]) send_row(dir_tbl[j]);
    drain_wait();

    // Random strings: mostly whole sequences, some noise and cut-off leads.
    while (n_rand < RAND_ITEMS) begin
      str.delete();
      units = $urandom_range(1, 5);
      for (i = 0; i < units; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          str.push_back(8'($urandom_range(1, 8'h7F)));
        end else if (kind < 60) begin
          lead = $urandom_range(0, 1) ? 8'(8'hC4 + $urandom_range(0, 1))
                                      : 8'($urandom_range(8'hC0, 8'hDF));
          str.push_back(lead);
          str.push_back(rand_follow());
        end else if (kind < 80) begin
          str.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          str.push_back(rand_follow());
          str.push_back(rand_follow());
        end else if (kind < 90) begin
          str.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                             : 8'($urandom_range(8'hF0, 8'hFF)));
        end else begin
          lead = $urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hDF))
                                      : 8'($urandom_range(8'hE0, 8'hEF));
          str.push_back(lead);
          if (lead >= 8'hE0 && $urandom_range(0, 1)) str.push_back(rand_follow());
        end
      end
      for (i = 0; i < str.size(); i++) begin
        no_idle = (n_rand >= RAND_ITEMS - QUIET_TAIL);
        send_row(mk_row(str[i], i == str.size() - 1, -1));
        n_rand++;
      end
      if (n_rand >= 100) hold_req = 1'b1;
      if (n_rand >= 170 && !paused) begin
        paused = 1'b1;
        drain_wait();
      end
    end

    // Let the last results out, then wait on for any stray bytes.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    i = 0;
    while (decoded_q.size() != 0 && i < DRAIN_LIMIT) begin
      @(posedge clk_i);
      i++;
    end
    repeat (10) @(posedge clk_i);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never came out", decoded_q.size()));

    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bltd_pkg.sv
src/bltd_decode.sv
src/bltd_outbuf.sv
src/byte_level_token_decoder.sv
tb/sv/tb_byte_level_token_decoder.sv
